/* rtl/core/sha256_pkg.sv */
// SHA-256 hasher package: payload structs, FSM states, controller/datapath
// command and status structs, round constants. No dependencies.
`default_nettype none
package sha256_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [60:0] MAX_BYTES = 61'h1FFFFFFFFFFFFFFF;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] message_byte;
        logic       last_item;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_bits_255_192;
        logic [63:0] digest_bits_191_128;
        logic [63:0] digest_bits_127_64;
        logic [63:0] digest_bits_63_0;
        logic        length_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE_RUN,
        ST_PAD,
        ST_PAD_RUN,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_INPUT,
        BSEL_PAD,
        BSEL_ZERO
    } bsel_t;

    // controller to datapath
    typedef struct packed {
        logic  put;        // write one byte at the fill position
        bsel_t bsel;
        logic  count;      // advance the byte total
        logic  set_ovf;
        logic  start;      // load schedule from block and working vars from chain
        logic  round;      // one compression round
        logic  put_len;    // write bit length into words 14 and 15
        logic  clear;      // back to initial state
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0] pos;       // fill position in block
        logic       at_max;
        logic       ovf;
        logic       last_round;
        logic       len_done;  // length already written this message
    } dp_sts_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sha256_datapath.sv */
// SHA-256 datapath: block buffer, schedule window, working vars, chain value,
// byte total. Depends on sha256_pkg.
`default_nettype none
module sha256_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         in_byte,
    input  wire sha256_pkg::dp_cmd_t cmd,
    output sha256_pkg::dp_sts_t     sts,
    output logic [255:0]            digest
);
    logic [31:0] block_reg [16];
    logic [31:0] block_next [16];
    logic [31:0] sched_reg [16];
    logic [31:0] vars_reg [8];
    logic [31:0] chain_reg [8];
    logic [60:0] total_reg;
    logic [5:0]  fill_reg;
    logic        ovf_reg;
    logic        len_reg;
    logic [5:0]  rnd_reg;

    logic [7:0]  wbyte;
    logic [5:0]  pos;
    logic [31:0] w, g0, g1, x15, x2, s1, ch, t1, s0, mj;
    logic [63:0] bits;

    // fill position advances on every byte written, message or pad
    assign pos  = fill_reg;
    assign bits = {total_reg, 3'b000};

    always_comb begin
        case (cmd.bsel)
            sha256_pkg::BSEL_INPUT: wbyte = in_byte;
            sha256_pkg::BSEL_PAD:   wbyte = sha256_pkg::PAD_BYTE;
            default:                wbyte = 8'h00;
        endcase
    end

    // block with this cycle's writes applied, so start sees the final byte
    always_comb begin
        for (int i = 0; i < 16; i++) block_next[i] = block_reg[i];
        if (cmd.put) begin
            block_next[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = wbyte;
        end
        if (cmd.put_len) begin
            block_next[14] = bits[63:32];
            block_next[15] = bits[31:0];
        end
    end

    // window slides: index 0 is always the current word
    always_comb begin
        x15 = sched_reg[1];
        x2  = sched_reg[14];
        g0  = sha256_pkg::ror32(x15, 7) ^ sha256_pkg::ror32(x15, 18) ^ (x15 >> 3);
        g1  = sha256_pkg::ror32(x2, 17) ^ sha256_pkg::ror32(x2, 19) ^ (x2 >> 10);
        w   = sched_reg[0];
        s1  = sha256_pkg::ror32(vars_reg[4], 6) ^ sha256_pkg::ror32(vars_reg[4], 11)
            ^ sha256_pkg::ror32(vars_reg[4], 25);
        ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        t1  = vars_reg[7] + s1 + ch + sha256_pkg::ROUND_K[rnd_reg] + w;
        s0  = sha256_pkg::ror32(vars_reg[0], 2) ^ sha256_pkg::ror32(vars_reg[0], 13)
            ^ sha256_pkg::ror32(vars_reg[0], 22);
        mj  = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
            ^ (vars_reg[1] & vars_reg[2]);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) block_reg[i] <= block_next[i];
        if (cmd.start) begin
            for (int i = 0; i < 16; i++) sched_reg[i] <= block_next[i];
            for (int i = 0; i < 8; i++) vars_reg[i] <= chain_reg[i];
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= sched_reg[0] + g0 + sched_reg[9] + g1;
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + s0 + mj;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= sha256_pkg::INIT_HASH[i];
            total_reg <= '0;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            len_reg   <= 1'b0;
            rnd_reg   <= '0;
        end else begin
            if (cmd.count) total_reg <= total_reg + 61'd1;
            if (cmd.put) fill_reg <= fill_reg + 6'd1;
            if (cmd.set_ovf) ovf_reg <= 1'b1;
            if (cmd.put_len) len_reg <= 1'b1;
            if (cmd.start) rnd_reg <= '0;
            else if (cmd.round) begin
                rnd_reg <= rnd_reg + 6'd1;
                // last round: fold working vars into chain using next values
                if (rnd_reg == sha256_pkg::LAST_ROUND) begin
                    chain_reg[0] <= chain_reg[0] + t1 + s0 + mj;
                    chain_reg[1] <= chain_reg[1] + vars_reg[0];
                    chain_reg[2] <= chain_reg[2] + vars_reg[1];
                    chain_reg[3] <= chain_reg[3] + vars_reg[2];
                    chain_reg[4] <= chain_reg[4] + vars_reg[3] + t1;
                    chain_reg[5] <= chain_reg[5] + vars_reg[4];
                    chain_reg[6] <= chain_reg[6] + vars_reg[5];
                    chain_reg[7] <= chain_reg[7] + vars_reg[6];
                end
            end
        end
    end

    always_comb begin
        sts.pos        = pos;
        sts.at_max     = (total_reg == sha256_pkg::MAX_BYTES);
        sts.ovf        = ovf_reg;
        sts.last_round = (rnd_reg == sha256_pkg::LAST_ROUND);
        sts.len_done   = len_reg;
        digest = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                  chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};
    end

`ifndef SYNTHESIS
    a_no_round_and_put: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.round && cmd.put)) else $error("put during compression");
    a_total_never_past_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count |-> !sts.at_max) else $error("byte total past limit");
    a_round_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.round && sts.last_round && !cmd.clear) |=> (rnd_reg == 6'd0))
        else $error("round counter did not wrap");
`endif
endmodule
`default_nettype wire

/* rtl/core/sha256_ctrl.sv */
// SHA-256 controller FSM: sequences byte loads, padding and compressions.
// Depends on sha256_pkg.
`default_nettype none
module sha256_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sha256_pkg::in_item_t s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     err,
    output sha256_pkg::dp_cmd_t      cmd,
    input  wire sha256_pkg::dp_sts_t sts
);
    sha256_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;
    logic err_reg, err_next;
    logic pad_started_reg, pad_started_next;
    logic take_byte, acc;

    assign acc       = s_valid && s_ready;
    assign take_byte = acc && s_item.has_byte && !sts.ovf && !sts.at_max;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sha256_pkg::ST_IDLE;
            last_reg        <= 1'b0;
            err_reg         <= 1'b0;
            pad_started_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            last_reg        <= last_next;
            err_reg         <= err_next;
            pad_started_reg <= pad_started_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (acc) begin
                    last_next = s_item.last_item;
                    if (take_byte && sts.pos == 6'd63) begin
                        state_next = sha256_pkg::ST_BYTE_RUN;
                    end else if (s_item.last_item) begin
                        if (sts.ovf || (s_item.has_byte && sts.at_max)) begin
                            err_next   = 1'b1;
                            state_next = sha256_pkg::ST_OUT;
                        end else begin
                            state_next = sha256_pkg::ST_PAD;
                        end
                    end
                end
            end
            sha256_pkg::ST_BYTE_RUN: begin
                if (sts.last_round) begin
                    state_next = last_reg ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_PAD: begin
                // block ends either full or with the length in words 14 and 15
                if ((pad_started_reg && sts.pos == sha256_pkg::LEN_POS) || sts.pos == 6'd63)
                    state_next = sha256_pkg::ST_PAD_RUN;
            end
            sha256_pkg::ST_PAD_RUN: begin
                if (sts.last_round) begin
                    state_next = sts.len_done ? sha256_pkg::ST_OUT : sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = sha256_pkg::ST_IDLE;
                    err_next   = 1'b0;
                    last_next  = 1'b0;
                end
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // pad: one byte per cycle at the fill position; 0x80 first, then zeros.
    // Once the marker is in, reaching position 56 means the length goes in.
    always_comb begin
        s_ready = (state_reg == sha256_pkg::ST_IDLE);
        m_valid = (state_reg == sha256_pkg::ST_OUT);
        err     = err_reg;
        cmd     = '0;
        cmd.bsel = sha256_pkg::BSEL_INPUT;
        pad_started_next = pad_started_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (take_byte) begin
                    cmd.put   = 1'b1;
                    cmd.count = 1'b1;
                    if (sts.pos == 6'd63) cmd.start = 1'b1;
                end
                if (acc && s_item.has_byte && (sts.ovf || sts.at_max)) cmd.set_ovf = 1'b1;
                pad_started_next = 1'b0;
            end
            sha256_pkg::ST_BYTE_RUN: begin
                cmd.round = 1'b1;
                pad_started_next = 1'b0;
            end
            sha256_pkg::ST_PAD: begin
                pad_started_next = 1'b1;
                if (pad_started_reg && sts.pos == sha256_pkg::LEN_POS) begin
                    cmd.put_len = 1'b1;
                    cmd.start   = 1'b1;
                end else begin
                    cmd.put  = 1'b1;
                    cmd.bsel = pad_started_reg ? sha256_pkg::BSEL_ZERO : sha256_pkg::BSEL_PAD;
                    if (sts.pos == 6'd63) cmd.start = 1'b1;
                end
            end
            sha256_pkg::ST_PAD_RUN: begin
                cmd.round = 1'b1;
            end
            sha256_pkg::ST_OUT: begin
                if (m_ready) cmd.clear = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_out_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (state_reg == sha256_pkg::ST_IDLE && !err_reg))
        else $error("no return to idle");
    a_start_not_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round |-> !cmd.start) else $error("start during rounds");
`endif
endmodule
`default_nettype wire

/* rtl/core/sha256_message_hasher.sv */
// SHA-256 message hasher top: one byte per word in, digest word out.
// A byte taken at a block end holds input off through the 64 rounds; others do not.
// Message end: one or two pad passes, each followed by 64 rounds.
// Throughput is set by the single round unit.
// Reset aresetn is synchronous, active low; returns to the initial hash state.
// Depends on sha256_pkg, sha256_ctrl, sha256_datapath.
`default_nettype none
module sha256_message_hasher (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sha256_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sha256_pkg::out_item_t      m_data
);
    sha256_pkg::dp_cmd_t cmd;
    sha256_pkg::dp_sts_t sts;
    logic [255:0] digest;
    logic err;

    sha256_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item(s_data),
        .m_valid, .m_ready, .err, .cmd, .sts
    );

    sha256_datapath u_dp (
        .aclk, .aresetn, .in_byte(s_data.message_byte), .cmd, .sts, .digest
    );

    always_comb begin
        m_data.length_error        = err;
        m_data.digest_bits_255_192 = err ? 64'd0 : digest[255:192];
        m_data.digest_bits_191_128 = err ? 64'd0 : digest[191:128];
        m_data.digest_bits_127_64  = err ? 64'd0 : digest[127:64];
        m_data.digest_bits_63_0    = err ? 64'd0 : digest[63:0];
    end
endmodule
`default_nettype wire

/* sim/tb_sha256_message_hasher.sv */
// Testbench for sha256_message_hasher: streams messages a byte per word and
// checks each digest word against a SHA-256 predictor. Depends on sha256_pkg, sha256_message_hasher.
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_message_hasher;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    sha256_pkg::in_item_t s_data;
    logic m_valid;
    logic m_ready;
    sha256_pkg::out_item_t m_data;

    sha256_message_hasher uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [63:0] BYTE_LIMIT = 64'h1FFFFFFFFFFFFFFF;

    // predictor state
    logic [31:0] hash_h [8];
    logic [31:0] blk [16];
    logic [63:0] nbytes;
    logic        ovf;

    sha256_pkg::out_item_t digest_q [$];
    int  errors;
    int  n_digests;
    int  n_words;
    longint cycles;

    typedef struct packed {
        sha256_pkg::in_item_t  word;
        logic                  known;   // expected digest typed in
        sha256_pkg::out_item_t digest;
    } row_t;

    function automatic logic [31:0] rr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 64; i++) begin
            if (i < 16)
                w[i] = blk[i];
            else
                w[i] = w[i-16] + w[i-7]
                    + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
                    + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    task automatic put_byte(input int pos, input logic [7:0] b);
        if (pos % 4 == 0) blk[pos/4] = {b, 24'h0};
        else blk[pos/4][(3 - pos % 4)*8 +: 8] = b;
    endtask

    task automatic hasher_clear();
        for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        nbytes = '0;
        ovf = 1'b0;
    endtask

    // advance the predictor by one accepted word; returns 1 with a digest at message end
    task automatic hasher_step(input sha256_pkg::in_item_t it, output bit got,
                               output sha256_pkg::out_item_t d);
        int pos;
        logic [63:0] bits;
        got = 0;
        d = '0;
        if (it.has_byte) begin
            if (ovf || nbytes >= BYTE_LIMIT) begin
                ovf = 1'b1;
            end else begin
                pos = int'(nbytes[5:0]);
                put_byte(pos, it.message_byte);
                nbytes++;
                if (pos == 63) compress_block();
            end
        end
        if (!it.last_item) return;
        got = 1;
        if (ovf) begin
            d.length_error = 1'b1;
        end else begin
            bits = nbytes << 3;
            pos = int'(nbytes[5:0]);
            put_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin put_byte(pos, 8'h00); pos++; end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin put_byte(pos, 8'h00); pos++; end
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            compress_block();
            d.digest_bits_255_192 = {hash_h[0], hash_h[1]};
            d.digest_bits_191_128 = {hash_h[2], hash_h[3]};
            d.digest_bits_127_64  = {hash_h[4], hash_h[5]};
            d.digest_bits_63_0    = {hash_h[6], hash_h[7]};
        end
        hasher_clear();
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("timeout after %0d cycles", cycles);
                $display("tb_sha256_message_hasher failed");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid drops only for a gap, so back-to-back words see one assignment per edge
    task automatic send_word(input sha256_pkg::in_item_t it);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_words++;
    endtask

    // result side: random stalls, compare against the oldest expected digest
    initial begin
        int g;
        sha256_pkg::out_item_t exp_d;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, m_data);
                errors++;
            end else begin
                exp_d = digest_q.pop_front();
                n_digests++;
                if (m_data.digest_bits_255_192 !== exp_d.digest_bits_255_192 ||
                    m_data.digest_bits_191_128 !== exp_d.digest_bits_191_128 ||
                    m_data.digest_bits_127_64 !== exp_d.digest_bits_127_64 ||
                    m_data.digest_bits_63_0 !== exp_d.digest_bits_63_0 ||
                    m_data.length_error !== exp_d.length_error) begin
                    $display("%0t: digest mismatch expected %h_%h_%h_%h err %b",
                             $time, exp_d.digest_bits_255_192,
                             exp_d.digest_bits_191_128, exp_d.digest_bits_127_64,
                             exp_d.digest_bits_63_0, exp_d.length_error);
                    $display("%0t:                   actual %h_%h_%h_%h err %b",
                             $time, m_data.digest_bits_255_192,
                             m_data.digest_bits_191_128, m_data.digest_bits_127_64,
                             m_data.digest_bits_63_0, m_data.length_error);
                    errors++;
                end
            end
        end
    end

    task automatic drive_checked(input sha256_pkg::in_item_t it, input bit known,
                                 input sha256_pkg::out_item_t kd);
        bit got;
        sha256_pkg::out_item_t d;
        hasher_step(it, got, d);
        if (got) begin
            if (known && d !== kd) begin
                $display("%0t: predictor disagrees with typed digest %h", $time, d);
                errors++;
            end
            digest_q.insert(digest_q.size(), known ? kd : d);
        end
        send_word(it);
    endtask

    function automatic sha256_pkg::in_item_t mk(input bit h, input logic [7:0] b,
                                                input bit l);
        sha256_pkg::in_item_t it;
        it.has_byte = h;
        it.message_byte = b;
        it.last_item = l;
        return it;
    endfunction

    initial begin
        row_t rows [14];
        row_t r;
        sha256_pkg::out_item_t none_d;
        sha256_pkg::out_item_t empty_d;
        sha256_pkg::out_item_t abc_d;
        int len;
        int kind;
        int n_msgs;
        logic [7:0] b;

        errors = 0; n_digests = 0; n_words = 0; n_msgs = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        hasher_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        none_d = '0;
        empty_d = '0;
        empty_d.digest_bits_255_192 = 64'he3b0c44298fc1c14;
        empty_d.digest_bits_191_128 = 64'h9afbf4c8996fb924;
        empty_d.digest_bits_127_64  = 64'h27ae41e4649b934c;
        empty_d.digest_bits_63_0    = 64'ha495991b7852b855;
        abc_d = '0;
        abc_d.digest_bits_255_192 = 64'hba7816bf8f01cfea;
        abc_d.digest_bits_191_128 = 64'h414140de5dae2223;
        abc_d.digest_bits_127_64  = 64'hb00361a396177a9c;
        abc_d.digest_bits_63_0    = 64'hb410ff61f20015ad;

        // directed: empty message, idle word, "abc", byte extremes, last with byte
        rows[0]  = '{mk(0, 8'h00, 1), 1'b1, empty_d};
        rows[1]  = '{mk(0, 8'hff, 0), 1'b0, none_d};
        rows[2]  = '{mk(1, 8'h61, 0), 1'b0, none_d};
        rows[3]  = '{mk(0, 8'h5a, 0), 1'b0, none_d};
        rows[4]  = '{mk(1, 8'h62, 0), 1'b0, none_d};
        rows[5]  = '{mk(1, 8'h63, 0), 1'b0, none_d};
        rows[6]  = '{mk(0, 8'h00, 1), 1'b1, abc_d};
        rows[7]  = '{mk(1, 8'h00, 1), 1'b0, none_d};
        rows[8]  = '{mk(1, 8'hff, 1), 1'b0, none_d};
        rows[9]  = '{mk(1, 8'h61, 0), 1'b0, none_d};
        rows[10] = '{mk(1, 8'h62, 0), 1'b0, none_d};
        rows[11] = '{mk(1, 8'h63, 1), 1'b1, abc_d};
        rows[12] = '{mk(0, 8'haa, 0), 1'b0, none_d};
        rows[13] = '{mk(0, 8'h55, 1), 1'b1, empty_d};
        foreach (rows[i]) begin
            r = rows[i];
            drive_checked(r.word, r.known, r.digest);
        end

        // random messages; lengths cluster around the padding boundaries
        while (n_words < 820) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: len = $urandom_range(0, 8);
                3, 4:    len = $urandom_range(54, 57);
                5:       len = $urandom_range(62, 65);
                6:       len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 70);
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    drive_checked(mk(0, 8'($urandom), 0), 1'b0, none_d);
                b = 8'($urandom);
                // the final byte sometimes carries the last flag itself
                drive_checked(mk(1, b, (i == len - 1) && $urandom_range(0, 1)),
                              1'b0, none_d);
            end
            if (nbytes != 0 || len == 0)
                drive_checked(mk(0, 8'($urandom), 1), 1'b0, none_d);
            n_msgs++;
        end
        s_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("%0d words sent in %0d random messages plus directed rows, %0d digests checked",
                 n_words, n_msgs, n_digests);
        $display("covered empty messages, idle words, pad-boundary and multi-block lengths");
        if (errors == 0) begin
            $display("tb_sha256_message_hasher passed");
        end else begin
            $display("tb_sha256_message_hasher failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
